### rtl/sxu_pkg.sv
// Shared constants for the segment intersection unit.
// No dependencies.
`default_nettype none
package sxu_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;
endpackage
`default_nettype wire

### rtl/sxu_front.sv
// Front end: differences, cross products, determinants, hit test.
// Depends on sxu_pkg. Four register stages, all advance on en.
`default_nettype none
module sxu_front #(
    parameter int COORD_BITS = sxu_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire logic signed [COORD_BITS-1:0] x1,
    input  wire logic signed [COORD_BITS-1:0] y1,
    input  wire logic signed [COORD_BITS-1:0] x2,
    input  wire logic signed [COORD_BITS-1:0] y2,
    input  wire logic signed [COORD_BITS-1:0] x3,
    input  wire logic signed [COORD_BITS-1:0] y3,
    input  wire logic signed [COORD_BITS-1:0] x4,
    input  wire logic signed [COORD_BITS-1:0] y4,
    output logic                              out_vld,
    output logic                              out_hit,
    output logic [2*COORD_BITS+1:0]           out_mtn,
    output logic [2*COORD_BITS+1:0]           out_mden,
    output logic [COORD_BITS:0]               out_mdx,
    output logic [COORD_BITS:0]               out_mdy,
    output logic                              out_negx,
    output logic                              out_negy,
    output logic signed [COORD_BITS-1:0]      out_bx,
    output logic signed [COORD_BITS-1:0]      out_by
);
    import sxu_pkg::*;
    localparam int DB = COORD_BITS + 1;
    localparam int PB = 2 * DB;
    localparam int NB = PB + 1;
    localparam int MB = PB;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DB-1:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, dx_reg, dy_reg;
    logic signed [COORD_BITS-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg, bx3_reg, by3_reg;

    function automatic logic signed [DB-1:0] sub(input logic signed [COORD_BITS-1:0] p,
                                                 input logic signed [COORD_BITS-1:0] q);
        sub = DB'(p) - DB'(q);
    endfunction

    // stage 2: products
    logic                 v2_reg;
    logic signed [PB-1:0] ab_reg, cd_reg, eb_reg, fd_reg, af_reg, ce_reg;
    logic signed [DB-1:0] dx2_reg, dy2_reg;

    // stage 3: determinants
    logic                 v3_reg;
    logic signed [NB-1:0] den_reg, tn_reg, un_reg;
    logic signed [DB-1:0] dx3_reg, dy3_reg;

    logic [MB-1:0] mden, mtn, mun;
    logic          hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            out_vld <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= in_vld;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            out_vld <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= sub(x1, x2);
            b_reg   <= sub(y3, y4);
            c_reg   <= sub(y1, y2);
            d_reg   <= sub(x3, x4);
            e_reg   <= sub(x1, x3);
            f_reg   <= sub(y1, y3);
            dx_reg  <= sub(x2, x1);
            dy_reg  <= sub(y2, y1);
            bx1_reg <= x1;
            by1_reg <= y1;

            ab_reg  <= a_reg * b_reg;
            cd_reg  <= c_reg * d_reg;
            eb_reg  <= e_reg * b_reg;
            fd_reg  <= f_reg * d_reg;
            af_reg  <= a_reg * f_reg;
            ce_reg  <= c_reg * e_reg;
            dx2_reg <= dx_reg;
            dy2_reg <= dy_reg;
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;

            den_reg <= NB'(ab_reg) - NB'(cd_reg);
            tn_reg  <= NB'(eb_reg) - NB'(fd_reg);
            un_reg  <= NB'(af_reg) - NB'(ce_reg);
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            bx3_reg <= bx2_reg;
            by3_reg <= by2_reg;

            out_hit  <= hit;
            out_mtn  <= mtn;
            out_mden <= mden;
            out_mdx  <= dx3_reg[DB-1] ? DB'(-dx3_reg) : DB'(dx3_reg);
            out_mdy  <= dy3_reg[DB-1] ? DB'(-dy3_reg) : DB'(dy3_reg);
            // on a hit tn and den share a sign, so the delta sign decides
            out_negx <= dx3_reg[DB-1];
            out_negy <= dy3_reg[DB-1];
            out_bx   <= bx3_reg;
            out_by   <= by3_reg;
        end
    end

    always_comb
    begin
        mden = den_reg[NB-1] ? MB'(-den_reg) : MB'(den_reg);
        mtn  = tn_reg[NB-1]  ? MB'(-tn_reg)  : MB'(tn_reg);
        mun  = un_reg[NB-1]  ? MB'(-un_reg)  : MB'(un_reg);
        hit  = (den_reg != '0)
            && (tn_reg != '0) && (tn_reg[NB-1] == den_reg[NB-1]) && (mtn < mden)
            && (un_reg != '0) && (un_reg[NB-1] != den_reg[NB-1]) && (mun < mden);
    end
endmodule
`default_nettype wire

### rtl/sxu_divstep.sv
// One restoring division step for both axes, registered.
// Depends on sxu_pkg.
`default_nettype none
module sxu_divstep #(
    parameter int COORD_BITS = sxu_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_vld,
    input  wire logic [2*COORD_BITS+1:0]   in_den,
    input  wire logic [2*COORD_BITS+1:0]   in_remx,
    input  wire logic [2*COORD_BITS+1:0]   in_remy,
    input  wire logic [COORD_BITS:0]       in_lowx,
    input  wire logic [COORD_BITS:0]       in_lowy,
    input  wire logic [COORD_BITS:0]       in_quox,
    input  wire logic [COORD_BITS:0]       in_quoy,
    output logic                           out_vld,
    output logic [2*COORD_BITS+1:0]        out_den,
    output logic [2*COORD_BITS+1:0]        out_remx,
    output logic [2*COORD_BITS+1:0]        out_remy,
    output logic [COORD_BITS:0]            out_lowx,
    output logic [COORD_BITS:0]            out_lowy,
    output logic [COORD_BITS:0]            out_quox,
    output logic [COORD_BITS:0]            out_quoy
);
    import sxu_pkg::*;
    localparam int DB = COORD_BITS + 1;
    localparam int MB = 2 * DB;

    logic [MB:0] tx, ty, dd;
    logic        gex, gey;

    always_comb
    begin
        dd  = {1'b0, in_den};
        tx  = {in_remx, in_lowx[DB-1]};
        ty  = {in_remy, in_lowy[DB-1]};
        gex = tx >= dd;
        gey = ty >= dd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld <= 1'b0;
        else if (en)
            out_vld <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_den  <= in_den;
            out_remx <= gex ? MB'(tx - dd) : tx[MB-1:0];
            out_remy <= gey ? MB'(ty - dd) : ty[MB-1:0];
            out_lowx <= {in_lowx[DB-2:0], 1'b0};
            out_lowy <= {in_lowy[DB-2:0], 1'b0};
            out_quox <= {in_quox[DB-2:0], gex};
            out_quoy <= {in_quoy[DB-2:0], gey};
        end
    end
endmodule
`default_nettype wire

### rtl/segment_intersection_unit.sv
// Segment intersection unit: one word per cycle while the output word is not stalled.
// Stages: 4 front (diff, mult, det, hit test), 1 scaling multiply, COORD_BITS+1
// division steps (one quotient bit each), 1 output register.
// The whole pipe freezes while the output word is stalled; in_stall follows that.
// Reset (rst_n, async low) clears all valid bits; payload registers are not reset.
`default_nettype none
module segment_intersection_unit #(
    parameter int COORD_BITS = sxu_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sxu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] wall_start_x,
    input  wire logic signed [COORD_BITS-1:0] wall_start_y,
    input  wire logic signed [COORD_BITS-1:0] wall_end_x,
    input  wire logic signed [COORD_BITS-1:0] wall_end_y,
    input  wire logic signed [COORD_BITS-1:0] ray_start_x,
    input  wire logic signed [COORD_BITS-1:0] ray_start_y,
    input  wire logic signed [COORD_BITS-1:0] ray_end_x,
    input  wire logic signed [COORD_BITS-1:0] ray_end_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              hit,
    output logic signed [COORD_BITS-1:0]      point_x,
    output logic signed [COORD_BITS-1:0]      point_y
);
    import sxu_pkg::*;
    localparam int DB = COORD_BITS + 1;   // delta / quotient width
    localparam int MB = 2 * DB;           // |den|, |tn| width
    localparam int PW = MB + DB;          // |tn|*|delta| width
    localparam int NS = DB;               // division steps
    localparam logic [COORD_BITS-1:0] MISS_VAL = '0 - (COORD_BITS'(1) << FRAC_BITS);

    // global advance: everything moves unless the output word is held
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---- front end ----
    logic                          f_vld, f_hit, f_negx, f_negy;
    logic [MB-1:0]                 f_mtn, f_mden;
    logic [DB-1:0]                 f_mdx, f_mdy;
    logic signed [COORD_BITS-1:0]  f_bx, f_by;

    sxu_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid),
        .x1(wall_start_x), .y1(wall_start_y), .x2(wall_end_x), .y2(wall_end_y),
        .x3(ray_start_x), .y3(ray_start_y), .x4(ray_end_x), .y4(ray_end_y),
        .out_vld(f_vld), .out_hit(f_hit), .out_mtn(f_mtn), .out_mden(f_mden),
        .out_mdx(f_mdx), .out_mdy(f_mdy), .out_negx(f_negx), .out_negy(f_negy),
        .out_bx(f_bx), .out_by(f_by)
    );

    // ---- scaling multiply: |tn| * |delta| per axis ----
    logic          m_vld_reg;
    logic [PW-1:0] m_px_reg, m_py_reg;
    logic [MB-1:0] m_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= f_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_px_reg  <= PW'(f_mtn) * PW'(f_mdx);
            m_py_reg  <= PW'(f_mtn) * PW'(f_mdy);
            // a miss may carry |den| = 0; the quotient is then unused
            m_den_reg <= f_mden;
        end
    end

    // sideband travels beside the divider, one slot per register stage
    logic                         sb_hit_reg  [0:NS];
    logic                         sb_negx_reg [0:NS];
    logic                         sb_negy_reg [0:NS];
    logic signed [COORD_BITS-1:0] sb_bx_reg   [0:NS];
    logic signed [COORD_BITS-1:0] sb_by_reg   [0:NS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_hit_reg[0]  <= f_hit;
            sb_negx_reg[0] <= f_negx;
            sb_negy_reg[0] <= f_negy;
            sb_bx_reg[0]   <= f_bx;
            sb_by_reg[0]   <= f_by;
            for (int i = 1; i <= NS; i++)
            begin
                sb_hit_reg[i]  <= sb_hit_reg[i-1];
                sb_negx_reg[i] <= sb_negx_reg[i-1];
                sb_negy_reg[i] <= sb_negy_reg[i-1];
                sb_bx_reg[i]   <= sb_bx_reg[i-1];
                sb_by_reg[i]   <= sb_by_reg[i-1];
            end
        end
    end

    // ---- divider chain: quotient < 2^DB since t < 1, so the top MB bits
    // of the product start below |den| ----
    logic          d_vld  [0:NS];
    logic [MB-1:0] d_den  [0:NS];
    logic [MB-1:0] d_remx [0:NS];
    logic [MB-1:0] d_remy [0:NS];
    logic [DB-1:0] d_lowx [0:NS];
    logic [DB-1:0] d_lowy [0:NS];
    logic [DB-1:0] d_quox [0:NS];
    logic [DB-1:0] d_quoy [0:NS];

    assign d_vld[0]  = m_vld_reg;
    assign d_den[0]  = m_den_reg;
    assign d_remx[0] = m_px_reg[PW-1:DB];
    assign d_remy[0] = m_py_reg[PW-1:DB];
    assign d_lowx[0] = m_px_reg[DB-1:0];
    assign d_lowy[0] = m_py_reg[DB-1:0];
    assign d_quox[0] = '0;
    assign d_quoy[0] = '0;

    for (genvar g = 0; g < NS; g++)
    begin : g_div
        sxu_divstep #(.COORD_BITS(COORD_BITS)) u_step (
            .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld[g]),
            .in_den(d_den[g]), .in_remx(d_remx[g]), .in_remy(d_remy[g]),
            .in_lowx(d_lowx[g]), .in_lowy(d_lowy[g]),
            .in_quox(d_quox[g]), .in_quoy(d_quoy[g]),
            .out_vld(d_vld[g+1]), .out_den(d_den[g+1]),
            .out_remx(d_remx[g+1]), .out_remy(d_remy[g+1]),
            .out_lowx(d_lowx[g+1]), .out_lowy(d_lowy[g+1]),
            .out_quox(d_quox[g+1]), .out_quoy(d_quoy[g+1])
        );
    end

    // ---- output: apply sign, add base, or force the miss value ----
    // sideband slot NS lines up with divider output NS
    logic [DB-1:0] sum_x, sum_y;

    always_comb
    begin
        sum_x = sb_negx_reg[NS] ? DB'(sb_bx_reg[NS]) - d_quox[NS]
                                : DB'(sb_bx_reg[NS]) + d_quox[NS];
        sum_y = sb_negy_reg[NS] ? DB'(sb_by_reg[NS]) - d_quoy[NS]
                                : DB'(sb_by_reg[NS]) + d_quoy[NS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= d_vld[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit     <= sb_hit_reg[NS];
            point_x <= sb_hit_reg[NS] ? sum_x[COORD_BITS-1:0] : MISS_VAL;
            point_y <= sb_hit_reg[NS] ? sum_y[COORD_BITS-1:0] : MISS_VAL;
        end
    end

`ifndef SYNTHESIS
    // a miss always carries -1.0 on both axes
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (point_x == MISS_VAL && point_y == MISS_VAL))
        else $error("miss word without -1.0 coordinates");

    // input is held off only while the output word is stalled
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // a frozen pipe keeps the last divider stage's valid unchanged
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(d_vld[NS]))
        else $error("divider output moved during stall");

    // an accepted input word lands in the first front stage
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_stall && in_valid) |=> u_front.v1_reg)
        else $error("pipeline lost an entering word");
`endif
endmodule
`default_nettype wire

### bench/tb_segment_intersection_unit.sv
// Self-checking bench for segment_intersection_unit: random and directed segment pairs,
// predicted crossing points compared word by word. Depends on rtl/sxu_pkg.sv and the RTL.
module tb_segment_intersection_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = sxu_pkg::COORD_BITS_DEF;
    localparam int FW = sxu_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM = 1630;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x1, y1, x2, y2, x3, y3, x4, y4;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        coord_t px;
        coord_t py;
    } crossing_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t wall_start_x = '0, wall_start_y = '0, wall_end_x = '0, wall_end_y = '0;
    coord_t ray_start_x = '0, ray_start_y = '0, ray_end_x = '0, ray_end_y = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;
    coord_t point_x, point_y;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int        n_errors = 0;
    bit        stim_done = 1'b0;

    segment_intersection_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .wall_start_x(wall_start_x), .wall_start_y(wall_start_y),
        .wall_end_x(wall_end_x), .wall_end_y(wall_end_y),
        .ray_start_x(ray_start_x), .ray_start_y(ray_start_y),
        .ray_end_x(ray_end_x), .ray_end_y(ray_end_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .point_x(point_x), .point_y(point_y)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Crossing point of one pair. Products fit easily in 64 bits at 16-bit coords;
    // the scaled numerator tn*delta needs up to ~51 bits, so 128 is generous.
    function automatic crossing_t predict_crossing(seg_pair_t p);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint den, tn, un, adn;
        logic signed [127:0] prod, q;
        bit t_ok, u_ok;
        crossing_t r;
        begin
            x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2;
            x3 = p.x3; y3 = p.y3; x4 = p.x4; y4 = p.y4;
            den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
            tn  = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
            un  = (x1 - x2) * (y1 - y3) - (y1 - y2) * (x1 - x3);
            adn = den < 0 ? -den : den;
            t_ok = tn != 0 && ((tn < 0) == (den < 0)) && (tn < 0 ? -tn : tn) < adn;
            u_ok = un != 0 && ((un < 0) != (den < 0)) && (un < 0 ? -un : un) < adn;
            if (den != 0 && t_ok && u_ok)
            begin
                r.hit = 1'b1;
                // SV signed division truncates toward zero, as required
                prod = 128'(signed'(tn)) * 128'(signed'(x2 - x1));
                q = prod / 128'(signed'(den));
                r.px = coord_t'(x1 + longint'(q));
                prod = 128'(signed'(tn)) * 128'(signed'(y2 - y1));
                q = prod / 128'(signed'(den));
                r.py = coord_t'(y1 + longint'(q));
            end
            else
            begin
                r.hit = 1'b0;
                r.px = -coord_t'(1 << FW);
                r.py = -coord_t'(1 << FW);
            end
            return r;
        end
    endfunction

    function automatic coord_t rand_coord();
        int m;
        begin
            m = $urandom_range(0, 9);
            // mostly small coords so crossings are common; sometimes full range
            if (m < 6)
                return coord_t'($signed($urandom_range(0, 1023)) - 512);
            else if (m < 8)
                return coord_t'($urandom);
            else
                return m == 8 ? coord_t'(16'h7fff) : coord_t'(16'h8000);
        end
    endfunction

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t p;
        begin
            p.x1 = coord_t'(a); p.y1 = coord_t'(b); p.x2 = coord_t'(c); p.y2 = coord_t'(d);
            p.x3 = coord_t'(e); p.y3 = coord_t'(f); p.x4 = coord_t'(g); p.y4 = coord_t'(h);
            return p;
        end
    endfunction

    // Stimulus: directed corner cases, then crossing-biased random pairs.
    initial
    begin
        seg_pair_t p;
        int cx, cy, k;
        pending_pairs.push_back(mk(-160, 0, 160, 0, 0, -160, 0, 160));   // plain cross
        pending_pairs.push_back(mk(0, 0, 160, 0, 0, 16, 160, 16));       // parallel
        pending_pairs.push_back(mk(0, 0, 160, 0, 16, 0, 80, 0));         // collinear
        pending_pairs.push_back(mk(0, 0, 0, 0, 5, 5, 9, 9));             // degenerate wall
        pending_pairs.push_back(mk(0, 0, 160, 0, 0, -16, 0, 16));        // touches wall start
        pending_pairs.push_back(mk(0, 0, 160, 0, 160, -16, 160, 16));    // touches wall end
        pending_pairs.push_back(mk(-16, 0, 16, 0, 0, 0, 0, 16));         // ray starts on wall
        pending_pairs.push_back(mk(-16, 0, 16, 0, 0, 16, 0, 0));         // ray ends on wall
        pending_pairs.push_back(mk(-16, 0, 16, 0, 0, 32, 0, 16));        // ray short of wall
        pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        pending_pairs.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        pending_pairs.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(0, 0, 3, 7, 0, 5, 3, 1));             // truncation
        pending_pairs.push_back(mk(0, 0, -3, -7, 0, -5, -3, -1));
        pending_pairs.push_back(mk(5, -9, -13, 11, -7, -4, 9, 6));
        for (k = 0; k < N_RANDOM; k++)
        begin
            p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            if ($urandom_range(0, 1) == 0)
            begin
                // aim both segments through a shared point so most of these hit
                cx = $signed($urandom_range(0, 4095)) - 2048;
                cy = $signed($urandom_range(0, 4095)) - 2048;
                p.x2 = coord_t'(2 * cx - p.x1 % 4000); p.x1 = coord_t'(p.x1 % 4000);
                p.y2 = coord_t'(2 * cy - p.y1 % 4000); p.y1 = coord_t'(p.y1 % 4000);
                p.x4 = coord_t'(2 * cx - p.x3 % 4000); p.x3 = coord_t'(p.x3 % 4000);
                p.y4 = coord_t'(2 * cy - p.y3 % 4000); p.y3 = coord_t'(p.y3 % 4000);
            end
            pending_pairs.push_back(p);
        end
        stim_done = 1'b1;
    end

    // Driver: bursts of back-to-back words separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
            if (in_valid && in_stall)
                ; // hold the stalled word
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() > (in_valid && !in_stall ? 0 : 0))
            begin
                in_valid <= 1'b1;
                wall_start_x <= pending_pairs[0].x1; wall_start_y <= pending_pairs[0].y1;
                wall_end_x <= pending_pairs[0].x2;   wall_end_y <= pending_pairs[0].y2;
                ray_start_x <= pending_pairs[0].x3;  ray_start_y <= pending_pairs[0].y3;
                ray_end_x <= pending_pairs[0].x4;    ray_end_y <= pending_pairs[0].y4;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern: phases of no stall, light stall and heavy stall.
    int stall_phase = 0;
    int phase_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (phase_left == 0)
            begin
                stall_phase <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
            end
            else
                phase_left <= phase_left - 1;
            case (stall_phase)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        crossing_t exp_c;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_crossings.size() == 0)
            begin
                $error("result word with no prediction pending");
                n_errors++;
            end
            else
            begin
                exp_c = expected_crossings.pop_front();
                if (hit !== exp_c.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_c.hit, hit);
                    n_errors++;
                end
                if (point_x !== exp_c.px)
                begin
                    $error("point_x: expected %0d, got %0d", exp_c.px, point_x);
                    n_errors++;
                end
                if (point_y !== exp_c.py)
                begin
                    $error("point_y: expected %0d, got %0d", exp_c.py, point_y);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_pairs.size() == 0);
        @(posedge clk);
        while (in_valid || expected_crossings.size() != 0)
            @(posedge clk);
        // drain: leave margin for stray words
        repeat (4 * (CW + 7)) @(posedge clk);
        if (n_errors == 0 && expected_crossings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
rtl/sxu_pkg.sv
rtl/sxu_front.sv
rtl/sxu_divstep.sv
rtl/segment_intersection_unit.sv
bench/tb_segment_intersection_unit.sv
